// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define VBCF_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("vbcf check failed");

// next-cycle implication, active during reset
`define VBCF_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("vbcf check failed");

`endif

// ----- rtl/core/vbcf_pkg.sv -----
// types and constants of the vertex box contact force block
package vbcf_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int GAIN_W    = 31;
    localparam int MAG_W     = 33;
    localparam int UNIT_W    = 17;
    localparam int SQ_W      = 64;
    localparam int ROOT_W    = 32;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_MIN   = 3'd0,
        REG_X_MAX   = 3'd1,
        REG_TOP_Y   = 3'd2,
        REG_Z_MIN   = 3'd3,
        REG_Z_MAX   = 3'd4,
        REG_SPRING  = 3'd5,
        REG_DAMPING = 3'd6
    } cfg_reg_e;

    typedef struct packed {
        coord_t x_min;
        coord_t x_max;
        coord_t top_y;
        coord_t z_min;
        coord_t z_max;
    } box_t;

    typedef struct packed {
        logic [GAIN_W-1:0] spring;
        logic [GAIN_W-1:0] damping;
    } gain_t;

    typedef struct packed {
        logic                     in_box;
        logic                     began;
        logic [2:0]               d_neg;
        logic [2:0][MAG_W-1:0]    d_mag;
        logic [2:0]               v_neg;
        logic [2:0][COORD_W-1:0]  v_mag;
    } work_t;

endpackage

// ----- rtl/core/vbcf_front.sv -----
// front end: penetration test, contact state, anchor and difference vector
module vbcf_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  vbcf_pkg::box_t  box,
    input  logic            in_valid,
    output logic            in_ready,
    input  vbcf_pkg::coord_t pos_x,
    input  vbcf_pkg::coord_t pos_y,
    input  vbcf_pkg::coord_t pos_z,
    input  vbcf_pkg::coord_t vel_x,
    input  vbcf_pkg::coord_t vel_y,
    input  vbcf_pkg::coord_t vel_z,
    output logic            push_valid,
    input  logic            push_ready,
    output vbcf_pkg::work_t push_data
);
    import vbcf_pkg::*;

    logic   contact_reg;
    coord_t anchor_reg [3];
    coord_t prev_reg   [3];
    coord_t pos [3];
    coord_t vel [3];
    coord_t anchor_eff [3];
    logic signed [MAG_W-1:0] diff [3];
    logic in_box;
    logic began;
    logic accept;

    assign pos[0] = pos_x;
    assign pos[1] = pos_y;
    assign pos[2] = pos_z;
    assign vel[0] = vel_x;
    assign vel[1] = vel_y;
    assign vel[2] = vel_z;

    assign in_box = (pos_x > box.x_min) && (pos_x < box.x_max) && (pos_y < box.top_y) &&
                    (pos_z > box.z_min) && (pos_z < box.z_max);
    assign began  = in_box && !contact_reg;
    assign accept = in_valid && push_ready;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    always_comb begin
        push_data.in_box = in_box;
        push_data.began  = began;
        for (int i = 0; i < 3; i++) begin
            anchor_eff[i] = began ? prev_reg[i] : anchor_reg[i];
            diff[i] = {anchor_eff[i][COORD_W-1], anchor_eff[i]} - {pos[i][COORD_W-1], pos[i]};
            push_data.d_neg[i] = diff[i][MAG_W-1];
            push_data.d_mag[i] = diff[i][MAG_W-1] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
            push_data.v_neg[i] = vel[i][COORD_W-1];
            push_data.v_mag[i] = vel[i][COORD_W-1] ? COORD_W'(-vel[i]) : COORD_W'(vel[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            contact_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                anchor_reg[i] <= '0;
                prev_reg[i]   <= '0;
            end
        end else if (accept) begin
            contact_reg <= in_box;
            for (int i = 0; i < 3; i++) begin
                if (began) begin
                    anchor_reg[i] <= prev_reg[i];
                end
                prev_reg[i] <= pos[i];
            end
        end
    end

endmodule

// ----- rtl/core/vbcf_queue.sv -----
// two-entry queue between front end and back end
module vbcf_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  vbcf_pkg::work_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output vbcf_pkg::work_t pop_data
);
    import vbcf_pkg::*;

    work_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ----- rtl/core/vbcf_back.sv -----
// back end: normalize, square root, divide, gain products, saturation, result register
module vbcf_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  vbcf_pkg::gain_t   gain,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  vbcf_pkg::work_t   pop_data,
    output logic              out_valid,
    input  logic              out_ready,
    output vbcf_pkg::coord_t  force_x,
    output vbcf_pkg::coord_t  force_y,
    output vbcf_pkg::coord_t  force_z,
    output logic              in_contact,
    output logic              contact_began
);
    import vbcf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_NORM, ST_SQ, ST_SQSUM, ST_SQRT, ST_DIV, ST_MUL, ST_OUT
    } state_t;

    localparam logic [MAG_W-1:0] LIM_FAST = MAG_W'(1) << 25;
    localparam logic [MAG_W-1:0] LIM_LOW  = MAG_W'(1) << 29;
    localparam logic [MAG_W-1:0] LIM_HIGH = MAG_W'(1) << 30;
    localparam logic signed [48:0] SAT_HI = 49'sd2147483647;
    localparam logic signed [48:0] SAT_LO = -49'sd2147483648;

    state_t                state_reg;
    logic [4:0]            cnt_reg;
    logic                  in_box_reg;
    logic                  began_reg;
    logic [2:0]            dneg_reg;
    logic [2:0]            vneg_reg;
    logic [MAG_W-1:0]      n_reg    [3];
    logic [MAG_W-1:0]      big_reg;
    logic [COORD_W-1:0]    vmag_reg [3];
    logic [59:0]           sq_reg   [3];
    logic [SQ_W-1:0]       x_reg;
    logic [SQ_W-1:0]       res_reg;
    logic [MAG_W-1:0]      rem_reg  [3];
    logic [UNIT_W-1:0]     q_reg    [3];
    logic [COORD_W-1:0]    sp_reg   [3];
    logic [46:0]           dp_reg   [3];
    logic                  out_valid_reg;
    coord_t                force_reg [3];
    logic                  contact_out_reg;
    logic                  began_out_reg;

    logic [SQ_W-1:0]       sq_bit;
    logic [SQ_W-1:0]       sq_trial;
    logic                  out_free;
    logic                  out_load;
    logic signed [48:0]    f_val [3];
    coord_t                f_sat [3];
    logic                  rem_ge [3];
    logic [MAG_W-1:0]      rem_sub [3];

    assign pop_ready     = (state_reg == ST_IDLE);
    assign out_free      = !out_valid_reg || out_ready;
    assign out_load      = (state_reg == ST_OUT) && out_free;
    assign out_valid     = out_valid_reg;
    assign force_x       = force_reg[0];
    assign force_y       = force_reg[1];
    assign force_z       = force_reg[2];
    assign in_contact    = contact_out_reg;
    assign contact_began = began_out_reg;

    assign sq_bit   = SQ_W'(1) << {cnt_reg, 1'b0};
    assign sq_trial = res_reg + sq_bit;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rem_ge[i]  = (rem_reg[i] >= {1'b0, res_reg[ROOT_W-1:0]});
            rem_sub[i] = rem_ge[i] ? (rem_reg[i] - {1'b0, res_reg[ROOT_W-1:0]}) : rem_reg[i];
            f_val[i] = (dneg_reg[i] ? -$signed({17'b0, sp_reg[i]}) : $signed({17'b0, sp_reg[i]}))
                     - (vneg_reg[i] ? -$signed({2'b0, dp_reg[i]}) : $signed({2'b0, dp_reg[i]}));
            if (!in_box_reg) begin
                f_sat[i] = '0;
            end else if (f_val[i] > SAT_HI) begin
                f_sat[i] = COORD_W'(SAT_HI);
            end else if (f_val[i] < SAT_LO) begin
                f_sat[i] = COORD_W'(SAT_LO);
            end else begin
                f_sat[i] = COORD_W'(f_val[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (pop_valid) begin
                        in_box_reg <= pop_data.in_box;
                        began_reg  <= pop_data.began;
                        dneg_reg   <= pop_data.d_neg;
                        vneg_reg   <= pop_data.v_neg;
                        for (int i = 0; i < 3; i++) begin
                            n_reg[i]    <= pop_data.d_mag[i];
                            vmag_reg[i] <= pop_data.v_mag[i];
                            q_reg[i]    <= '0;
                            sp_reg[i]   <= '0;
                            dp_reg[i]   <= '0;
                        end
                        if (pop_data.d_mag[0] >= pop_data.d_mag[1] &&
                            pop_data.d_mag[0] >= pop_data.d_mag[2]) begin
                            big_reg <= pop_data.d_mag[0];
                        end else if (pop_data.d_mag[1] >= pop_data.d_mag[2]) begin
                            big_reg <= pop_data.d_mag[1];
                        end else begin
                            big_reg <= pop_data.d_mag[2];
                        end
                        state_reg <= pop_data.in_box ? ST_NORM : ST_OUT;
                    end
                end
                ST_NORM: begin
                    if (big_reg == '0) begin
                        state_reg <= ST_MUL;
                    end else if (big_reg < LIM_FAST) begin
                        big_reg <= big_reg << 4;
                        for (int i = 0; i < 3; i++) n_reg[i] <= n_reg[i] << 4;
                    end else if (big_reg < LIM_LOW) begin
                        big_reg <= big_reg << 1;
                        for (int i = 0; i < 3; i++) n_reg[i] <= n_reg[i] << 1;
                    end else if (big_reg >= LIM_HIGH) begin
                        big_reg <= big_reg >> 1;
                        for (int i = 0; i < 3; i++) n_reg[i] <= n_reg[i] >> 1;
                    end else begin
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    for (int i = 0; i < 3; i++) begin
                        sq_reg[i] <= n_reg[i][29:0] * n_reg[i][29:0];
                    end
                    state_reg <= ST_SQSUM;
                end
                ST_SQSUM: begin
                    x_reg     <= SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
                    res_reg   <= '0;
                    cnt_reg   <= 5'd31;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (x_reg >= sq_trial) begin
                        x_reg   <= x_reg - sq_trial;
                        res_reg <= (res_reg >> 1) + sq_bit;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    if (cnt_reg == 5'd0) begin
                        cnt_reg   <= 5'd16;
                        state_reg <= ST_DIV;
                        for (int i = 0; i < 3; i++) rem_reg[i] <= n_reg[i];
                    end else begin
                        cnt_reg <= cnt_reg - 5'd1;
                    end
                end
                ST_DIV: begin
                    for (int i = 0; i < 3; i++) begin
                        q_reg[i]   <= {q_reg[i][UNIT_W-2:0], rem_ge[i]};
                        rem_reg[i] <= rem_sub[i] << 1;
                    end
                    if (cnt_reg == 5'd0) begin
                        state_reg <= ST_MUL;
                    end else begin
                        cnt_reg <= cnt_reg - 5'd1;
                    end
                end
                ST_MUL: begin
                    for (int i = 0; i < 3; i++) begin
                        sp_reg[i] <= COORD_W'((48'(gain.spring) * 48'(q_reg[i])) >> FRAC_W);
                        dp_reg[i] <= 47'((63'(gain.damping) * 63'(vmag_reg[i])) >> FRAC_W);
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        contact_out_reg <= in_box_reg;
                        began_out_reg   <= began_reg;
                        for (int i = 0; i < 3; i++) force_reg[i] <= f_sat[i];
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/core/vertex_box_contact_force.sv -----
// top level of the vertex box contact force block
//   channel | dir | handshake             | content
//   s_axis  | in  | s_axis_tvalid/tready  | position and velocity of one vertex tick
//   m_axis  | out | m_axis_tvalid/tready  | contact force and contact flags
//   cfg     | in  | cfg_valid/cfg_ready   | box bounds and gains by register index
// outside the box an item goes straight to the output step, and a zero-length
// direction skips to the product step; otherwise the back end does normalize shifts,
// a 32-step square root, a 17-step divide in three lanes, a product step, an output step
// one item is worked at a time; the queue takes up to two more meanwhile
// synchronous active-low reset clears contact state, anchor, last position and registers
// a stalled result holds in the output register while the back end waits
module vertex_box_contact_force (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // force_x, force_y, force_z
    output logic [1:0]   m_axis_tuser,   // in_contact, contact_began
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [vbcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]  cfg_data
);
    import vbcf_pkg::*;

    box_t   box_reg;
    gain_t  gain_reg;
    logic   push_valid;
    logic   push_ready;
    work_t  push_data;
    logic   pop_valid;
    logic   pop_ready;
    work_t  pop_data;
    coord_t force_x;
    coord_t force_y;
    coord_t force_z;
    logic   in_contact;
    logic   contact_began;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg  <= '0;
            gain_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_reg_e'(cfg_index))
                REG_X_MIN:   box_reg.x_min    <= cfg_data;
                REG_X_MAX:   box_reg.x_max    <= cfg_data;
                REG_TOP_Y:   box_reg.top_y    <= cfg_data;
                REG_Z_MIN:   box_reg.z_min    <= cfg_data;
                REG_Z_MAX:   box_reg.z_max    <= cfg_data;
                REG_SPRING:  gain_reg.spring  <= cfg_data[GAIN_W-1:0];
                REG_DAMPING: gain_reg.damping <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    vbcf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .box        (box_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .pos_x      (s_axis_tdata[31:0]),
        .pos_y      (s_axis_tdata[63:32]),
        .pos_z      (s_axis_tdata[95:64]),
        .vel_x      (s_axis_tdata[127:96]),
        .vel_y      (s_axis_tdata[159:128]),
        .vel_z      (s_axis_tdata[191:160]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    vbcf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    vbcf_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .gain          (gain_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .force_x       (force_x),
        .force_y       (force_y),
        .force_z       (force_z),
        .in_contact    (in_contact),
        .contact_began (contact_began)
    );

    assign m_axis_tdata = {force_z, force_y, force_x};
    assign m_axis_tuser = {contact_began, in_contact};

endmodule

// ----- rtl/core/vbcf_checker.sv -----
// port-level checks of the vertex box contact force block
`include "assert_macros.svh"

module vbcf_assertions (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [95:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    logic began_out;
    logic free_out;
    logic stalled_out;

    assign began_out   = m_axis_tvalid && m_axis_tuser[1];
    assign free_out    = m_axis_tvalid && !m_axis_tuser[0];
    assign stalled_out = aresetn && m_axis_tvalid && !m_axis_tready;

    `VBCF_ASSERT_IMPL(a_began_in_contact, aclk, aresetn, began_out, m_axis_tuser[0])
    `VBCF_ASSERT_IMPL(a_no_contact_zero, aclk, aresetn, free_out, m_axis_tdata == 96'd0)
    `VBCF_ASSERT_NEXT(a_reset_clears_out, aclk, !aresetn, !m_axis_tvalid)
    `VBCF_ASSERT_NEXT(a_out_holds, aclk, stalled_out, m_axis_tvalid || !aresetn)

endmodule

bind vertex_box_contact_force vbcf_assertions u_vbcf_assertions (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
